// ----- rtl/ffws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ffws_pkg;

    // Series size: harmonics beyond the stored coefficient pairs contribute zero
    localparam int HARMONIC_COUNT   = 8;
    localparam int COEF_PAIRS       = 8;
    localparam int CELL_COUNT       = (HARMONIC_COUNT < COEF_PAIRS) ? HARMONIC_COUNT : COEF_PAIRS;

    // Quarter-wave sine table
    localparam int SINE_TABLE_DEPTH = 1024;
    localparam int SINE_ADDR_BITS   = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SINE_BITS        = 17;
    localparam longint SINE_ONE     = 65536;

    // Base rate in turns per second, Q0.32
    localparam logic [31:0] RATE_TURNS_Q32 = 32'd4294157061;
    localparam logic [31:0] QUARTER_TURN   = 32'h4000_0000;

    localparam logic [15:0] GAIN_RESET     = 16'd256;

    // Output buffer depth
    localparam int OUTBUF_DEPTH = 2;

    // Datapath widths
    localparam int COEF_W   = 25;
    localparam int SCALED_W = COEF_W + 16;
    localparam int TRIG_W   = SINE_BITS + 1;
    localparam int PROD_W   = SCALED_W + TRIG_W;
    localparam int SUM_W    = 60;
    localparam int FLOW_W   = 32;

    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [SCALED_W-1:0] scaled_t;
    typedef logic signed [TRIG_W-1:0]   trig_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [SUM_W-1:0]    sum_t;
    typedef logic [SINE_BITS-1:0]       sine_t;
    typedef logic [SINE_ADDR_BITS-1:0]  sine_addr_t;

    typedef coef_t coef_arr_t [COEF_PAIRS];
    typedef sine_t sine_tab_t [SINE_TABLE_DEPTH + 1];

    // Series coefficients, Q16 ml/s
    localparam coef_t MEAN_COEF = 25'sd6828851;
    localparam coef_arr_t COS_COEF = '{
        25'sd7798784, -25'sd1165885, -25'sd3050045, -25'sd1806172,
        -25'sd2127299, -25'sd1270088, -25'sd524419, -25'sd1040056
    };
    localparam coef_arr_t SIN_COEF = '{
        25'sd9351987, 25'sd8500019, 25'sd3264348, 25'sd1804861,
        25'sd1074790, -25'sd157876, 25'sd389415, 25'sd220987
    };

    // Link between neighboring cells
    typedef struct packed {
        logic        valid;
        logic [31:0] base;
        logic [31:0] ph;
        sum_t        sum;
    } link_t;

    // Q30 product, truncated toward zero
    function automatic longint mul_q30(input longint a, input longint b);
        longint p;
        p = a * b;
        if (p >= 0) begin
            return p >>> 30;
        end
        return -((-p) >>> 30);
    endfunction

    // Build the quarter-wave table from a degree-9 polynomial
    function automatic sine_tab_t build_sine_table();
        sine_tab_t tab;
        longint    u;
        longint    u2;
        longint    acc;
        longint    r;
        for (int i = 0; i <= SINE_TABLE_DEPTH; i++) begin
            u   = (longint'(i) <<< 30) / SINE_TABLE_DEPTH;
            u2  = (u * u) >>> 30;
            acc = 172272;
            acc = -5026995 + mul_q30(acc, u2);
            acc = 85569306 + mul_q30(acc, u2);
            acc = -693598668 + mul_q30(acc, u2);
            acc = 1686629713 + mul_q30(acc, u2);
            r   = mul_q30(acc, u);
            if (r < 0) begin
                r = 0;
            end
            r = (r + 8192) >>> 14;
            if (r > SINE_ONE) begin
                r = SINE_ONE;
            end
            tab[i] = r[SINE_BITS-1:0];
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

    // Coefficient times Q8.8 gain
    function automatic scaled_t scale_coef(input coef_t coef, input logic [15:0] gain);
        logic signed [SCALED_W:0] prod;
        prod = coef * $signed({1'b0, gain});
        return prod[SCALED_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/fourier_flow_waveform_synth.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Width  Contents
// s_*       in   32     time_value, unsigned Q16.16 seconds
// m_*       out  32     flow_value, signed, 1/256 ml/s
// cfg_*     in   16     flow_gain, unsigned Q8.8
//
// One beat per cycle in and out while the output queue has room. The path
// holds one phase multiply stage, four stages per harmonic cell, and the
// output queue.
// Reset clears the valid bits and the queue count and sets the gain to 1.0.
// The whole chain holds while the two-entry output queue is full; s_tready
// drops only then, so input keeps flowing while one result waits.

module fourier_flow_waveform_synth
    import ffws_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] time_value
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] flow_value
    input  wire logic        cfg_wen,
    input  wire logic [15:0] cfg_wdata
);

    logic        adv;
    logic [15:0] gain_reg;
    link_t       chain [CELL_COUNT + 1];
    scaled_t     cos_scaled_reg [CELL_COUNT];
    scaled_t     sin_scaled_reg [CELL_COUNT];
    sum_t        round_sum;
    logic [FLOW_W-1:0] flow_value;

    // Hold the gain register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_wen) begin
            gain_reg <= cfg_wdata;
        end
    end

    ffws_phase u_phase (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_tvalid),
        .time_value (s_tdata),
        .gain       (gain_reg),
        .link_out   (chain[0])
    );

    // One cell per harmonic, each with its gain-scaled coefficients
    for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
        always_ff @(posedge aclk) begin
            cos_scaled_reg[k] <= scale_coef(COS_COEF[k], gain_reg);
            sin_scaled_reg[k] <= scale_coef(SIN_COEF[k], gain_reg);
        end

        ffws_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .adv        (adv),
            .cos_scaled (cos_scaled_reg[k]),
            .sin_scaled (sin_scaled_reg[k]),
            .link_in    (chain[k]),
            .link_out   (chain[k+1])
        );
    end

    // Round to 1/256 ml/s; the series bound keeps the result inside 32 bits
    assign round_sum  = chain[CELL_COUNT].sum + (sum_t'(1) <<< 31);
    assign flow_value = FLOW_W'({{(FLOW_W-(SUM_W-32)){round_sum[SUM_W-1]}},
                                 round_sum[SUM_W-1:32]});

    ffws_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (chain[CELL_COUNT].valid),
        .push_data  (flow_value),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata),
        .room       (adv)
    );

    assign s_tready = adv;

endmodule

`default_nettype wire

// ----- rtl/ffws_phase.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ffws_phase
    import ffws_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        adv,
    input  wire logic        in_valid,
    input  wire logic [31:0] time_value,
    input  wire logic [15:0] gain,
    output link_t            link_out
);

    logic [63:0] phase_prod;
    logic        valid_reg;
    logic [31:0] phase_reg;
    scaled_t     mean_scaled_reg;

    // Time times rate; keep the Q0.32 turn
    assign phase_prod = {32'd0, time_value} * {32'd0, RATE_TURNS_Q32};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            phase_reg <= phase_prod[47:16];
        end
        mean_scaled_reg <= scale_coef(MEAN_COEF, gain);
    end

    // Seed the chain: harmonic zero phase, mean term as starting sum
    assign link_out.valid = valid_reg;
    assign link_out.base  = phase_reg;
    assign link_out.ph    = 32'd0;
    assign link_out.sum   = sum_t'({{(SUM_W-SCALED_W-16){mean_scaled_reg[SCALED_W-1]}},
                                    mean_scaled_reg, 16'd0});

endmodule

`default_nettype wire

// ----- rtl/ffws_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ffws_cell
    import ffws_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    adv,
    input  wire scaled_t cos_scaled,
    input  wire scaled_t sin_scaled,
    input  wire link_t   link_in,
    output link_t        link_out
);

    localparam int POS_W = 30 + SINE_ADDR_BITS;

    // Stage A: this harmonic's phase
    logic        a_valid_reg;
    logic [31:0] a_base_reg;
    logic [31:0] a_ph_reg;
    sum_t        a_sum_reg;

    // Stage B: table reads
    logic        b_valid_reg;
    logic [31:0] b_base_reg;
    logic [31:0] b_ph_reg;
    sum_t        b_sum_reg;
    sine_t       b_sin_reg;
    sine_t       b_cos_reg;
    logic        b_sin_neg_reg;
    logic        b_cos_neg_reg;

    // Stage C: products
    logic        c_valid_reg;
    logic [31:0] c_base_reg;
    logic [31:0] c_ph_reg;
    sum_t        c_sum_reg;
    prod_t       c_pc_reg;
    prod_t       c_ps_reg;

    // Stage D: accumulated sum
    logic        d_valid_reg;
    logic [31:0] d_base_reg;
    logic [31:0] d_ph_reg;
    sum_t        d_sum_reg;

    logic [31:0] cos_ph;
    sine_addr_t  sin_addr;
    sine_addr_t  cos_addr;
    trig_t       sin_trig;
    trig_t       cos_trig;
    sum_t        d_sum_next;

    // Map a turn to a table address; odd quadrants read the table backwards
    function automatic sine_addr_t turn_addr(input logic [31:0] ph);
        logic [POS_W-1:0] scaled_pos;
        sine_addr_t       idx;
        scaled_pos = POS_W'(ph[29:0]) * POS_W'(SINE_TABLE_DEPTH);
        idx        = scaled_pos[POS_W-1:30];
        if (ph[30]) begin
            return sine_addr_t'(SINE_TABLE_DEPTH) - idx;
        end
        return idx;
    endfunction

    assign cos_ph   = a_ph_reg + QUARTER_TURN;
    assign sin_addr = turn_addr(a_ph_reg);
    assign cos_addr = turn_addr(cos_ph);

    // Apply the sign of the lower half turn
    assign sin_trig = b_sin_neg_reg ? -$signed({1'b0, b_sin_reg}) : $signed({1'b0, b_sin_reg});
    assign cos_trig = b_cos_neg_reg ? -$signed({1'b0, b_cos_reg}) : $signed({1'b0, b_cos_reg});

    assign d_sum_next = c_sum_reg
                      + {{(SUM_W-PROD_W){c_pc_reg[PROD_W-1]}}, c_pc_reg}
                      + {{(SUM_W-PROD_W){c_ps_reg[PROD_W-1]}}, c_ps_reg};

    // Advance the valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= link_in.valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    // Advance the payload
    always_ff @(posedge aclk) begin
        if (adv) begin
            a_base_reg    <= link_in.base;
            a_ph_reg      <= link_in.ph + link_in.base;
            a_sum_reg     <= link_in.sum;

            b_base_reg    <= a_base_reg;
            b_ph_reg      <= a_ph_reg;
            b_sum_reg     <= a_sum_reg;
            b_sin_reg     <= SINE_TABLE[sin_addr];
            b_cos_reg     <= SINE_TABLE[cos_addr];
            b_sin_neg_reg <= a_ph_reg[31];
            b_cos_neg_reg <= cos_ph[31];

            c_base_reg    <= b_base_reg;
            c_ph_reg      <= b_ph_reg;
            c_sum_reg     <= b_sum_reg;
            c_pc_reg      <= cos_scaled * cos_trig;
            c_ps_reg      <= sin_scaled * sin_trig;

            d_base_reg    <= c_base_reg;
            d_ph_reg      <= c_ph_reg;
            d_sum_reg     <= d_sum_next;
        end
    end

    assign link_out.valid = d_valid_reg;
    assign link_out.base  = d_base_reg;
    assign link_out.ph    = d_ph_reg;
    assign link_out.sum   = d_sum_reg;

endmodule

`default_nettype wire

// ----- rtl/ffws_outbuf.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ffws_outbuf
    import ffws_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push_valid,
    input  wire logic [FLOW_W-1:0] push_data,
    input  wire logic              m_tready,
    output logic                   m_tvalid,
    output logic [FLOW_W-1:0]      m_tdata,
    output logic                   room
);

    localparam int CNT_W = $clog2(OUTBUF_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(OUTBUF_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [FLOW_W-1:0] head_reg;
    logic [FLOW_W-1:0] head_next;
    logic [FLOW_W-1:0] tail_reg;
    logic [FLOW_W-1:0] tail_next;
    logic              push;
    logic              pop;

    assign room     = (cnt_reg != CNT_FULL);
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = head_reg;
    assign push     = push_valid && room;
    assign pop      = m_tvalid && m_tready;

    // Two-entry queue: head drives the port, tail catches the stalled beat
    always_comb begin
        cnt_next  = cnt_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_ONE;
            if (cnt_reg == '0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
        end else if (pop && !push) begin
            cnt_next  = cnt_reg - CNT_ONE;
            head_next = tail_reg;
        end else if (push && pop) begin
            if (cnt_reg == CNT_ONE) begin
                head_next = push_data;
            end else begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

`default_nettype wire

// ----- rtl/ffws_check.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ffws_check (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // Reset empties the output queue
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result beat holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Input is open whenever no result waits
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty output");

    // Input closes only behind a waiting, unconsumed result
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_tready) |-> $past(m_tvalid) && $past(!m_tready))
        else $error("s_tready dropped without backpressure");

endmodule

bind fourier_flow_waveform_synth ffws_check u_ffws_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import ffws_pkg::*;

    // One pending flow value and the time sample that produced it
    typedef struct {
        logic [31:0] time_in;
        logic [31:0] flow;
    } flow_due_t;

    // Predicts the eight-harmonic flow series and checks the output stream in order
    class flow_checker;
        flow_due_t   flows_due[$];
        longint      quarter_wave[1025];
        longint      mean_q16;
        longint      cos_q16[8];
        longint      sin_q16[8];
        int          mismatches;
        int          checked;

        function new();
            longint u;
            longint u2;
            longint acc;
            longint r;
            mean_q16 = 6828851;
            cos_q16 = '{7798784, -1165885, -3050045, -1806172,
                        -2127299, -1270088, -524419, -1040056};
            sin_q16 = '{9351987, 8500019, 3264348, 1804861,
                        1074790, -157876, 389415, 220987};
            mismatches = 0;
            checked = 0;
            // Fill the quarter-wave sine from a degree-9 Taylor polynomial in Q30
            for (int i = 0; i <= 1024; i++) begin
                u   = (longint'(i) <<< 30) / 1024;
                u2  = (u * u) >>> 30;
                acc = 172272;
                acc = -5026995 + q30_trunc(acc, u2);
                acc = 85569306 + q30_trunc(acc, u2);
                acc = -693598668 + q30_trunc(acc, u2);
                acc = 1686629713 + q30_trunc(acc, u2);
                r   = q30_trunc(acc, u);
                if (r < 0) begin
                    r = 0;
                end
                r = (r + 8192) >>> 14;
                if (r > 65536) begin
                    r = 65536;
                end
                quarter_wave[i] = r;
            end
        endfunction

        // Product scaled down by 2^30, truncated toward zero
        function longint q30_trunc(input longint a, input longint b);
            longint p;
            p = a * b;
            if (p >= 0) begin
                return p >>> 30;
            end
            return -((-p) >>> 30);
        endfunction

        // Sine of a Q0.32 turn in Q16, no interpolation
        function longint sine_of_turn(input logic [31:0] turn);
            logic [9:0] idx;
            longint     v;
            idx = turn[29:20];
            if (turn[30]) begin
                v = quarter_wave[1024 - int'(idx)];
            end else begin
                v = quarter_wave[idx];
            end
            return turn[31] ? -v : v;
        endfunction

        function logic [31:0] predict_flow(input logic [31:0] t, input logic [15:0] gain);
            logic [63:0] spin;
            logic [31:0] base_turn;
            logic [31:0] ph;
            logic [31:0] phc;
            longint      g;
            longint      acc;
            longint      res;
            spin      = {32'd0, t} * 64'd4294157061;
            base_turn = spin[47:16];
            g         = longint'(gain);
            acc       = mean_q16 * g * 65536;
            for (int k = 1; k <= 8; k++) begin
                ph  = base_turn * k;
                phc = ph + 32'h4000_0000;
                acc += cos_q16[k-1] * g * sine_of_turn(phc);
                acc += sin_q16[k-1] * g * sine_of_turn(ph);
            end
            // Round at bit 31, floor-divide by 2^32, then saturate
            res = (acc + (longint'(1) <<< 31)) >>> 32;
            if (res > 64'sd2147483647) begin
                res = 64'sd2147483647;
            end
            if (res < -64'sd2147483648) begin
                res = -64'sd2147483648;
            end
            return res[31:0];
        endfunction

        function void note_time(input logic [31:0] t, input logic [15:0] gain);
            flow_due_t d;
            d.time_in = t;
            d.flow    = predict_flow(t, gain);
            flows_due.push_back(d);
        endfunction

        function void check_flow(input logic [31:0] got);
            flow_due_t d;
            if (flows_due.size() == 0) begin
                $display("%0t: flow_value %0d arrived with no time sample pending",
                         $time, $signed(got));
                mismatches++;
                return;
            end
            d = flows_due.pop_front();
            checked++;
            if (got !== d.flow) begin
                $display("%0t: flow_value mismatch for time_value %h: expected %0d, got %0d",
                         $time, d.time_in, $signed(d.flow), $signed(got));
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic        cfg_wen;
    logic [15:0] cfg_wdata;

    flow_checker flows = new();
    logic [15:0] gain_now = GAIN_RESET;
    int          gain_settings = 1;
    bit          quiet = 1'b0;
    bit          hold_req = 1'b0;

    fourier_flow_waveform_synth i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // [31:0] time_value
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // [31:0] flow_value
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Check every accepted output beat
    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            flows.check_flow(m_tdata);
        end
    end

    // Drive m_tready: random stall bursts, one long hold on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0 && !quiet) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Offer one time sample; returns at the falling edge after its beat, valid still high
    task automatic send_time(input logic [31:0] t, input bit may_idle);
        int gap;
        if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= t;
        do begin
            @(posedge aclk);
        end while (s_tready !== 1'b1);
        flows.note_time(t, gain_now);
        @(negedge aclk);
    endtask

    // Drop valid and hold until every pending flow value has come out
    task automatic drain_flows();
        s_tvalid <= 1'b0;
        while (flows.flows_due.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_gain(input logic [15:0] g);
        drain_flows();
        cfg_wen   <= 1'b1;
        cfg_wdata <= g;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        gain_now = g;
        gain_settings++;
    endtask

    // Mix of full-range, small, whole-second and near-wrap times
    function automatic logic [31:0] pick_time();
        case ($urandom_range(0, 9))
            0: return $urandom_range(0, 32'h0003_FFFF);
            1: return {16'hFFFF, 16'($urandom)};
            2: return {16'($urandom), 16'h0000};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [15:0] phase_gains [6];
        s_tvalid  = 1'b0;
        s_tdata   = 32'd0;
        cfg_wen   = 1'b0;
        cfg_wdata = 16'd0;
        aresetn   = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: field extremes, quarter turns, time wrap at the reset gain
        send_time(32'h0000_0000, 1'b0);
        send_time(32'h0000_0001, 1'b0);
        send_time(32'hFFFF_FFFF, 1'b0);
        send_time(32'h8000_0000, 1'b0);
        send_time(32'h7FFF_FFFF, 1'b0);
        send_time(32'h0001_0000, 1'b0);
        send_time(32'h0000_4000, 1'b0);
        send_time(32'h0000_8000, 1'b0);
        send_time(32'h0000_C000, 1'b0);
        send_time(32'hFFFF_0000, 1'b0);
        send_time(32'h5555_5555, 1'b0);
        send_time(32'hAAAA_AAAA, 1'b0);

        // Largest gain, aiming at the saturation corner
        write_gain(16'hFFFF);
        send_time(32'h0000_0000, 1'b0);
        send_time(32'h0000_4000, 1'b0);
        send_time(32'hFFFF_FFFF, 1'b0);
        send_time(32'hAAAA_AAAA, 1'b0);

        // Zero gain flattens the series
        write_gain(16'h0000);
        send_time(32'h5555_5555, 1'b0);
        send_time(32'hFFFF_FFFF, 1'b0);

        phase_gains = '{16'd1, 16'($urandom), 16'd256, 16'($urandom), 16'hFFFF,
                        16'($urandom)};
        for (int p = 0; p < 6; p++) begin
            write_gain(phase_gains[p]);
            if (p == 5) begin
                quiet = 1'b1;
            end
            for (int n = 0; n < 165; n++) begin
                if (p == 1 && n == 20) begin
                    // Long output hold while input keeps coming, filling the pipe
                    hold_req = 1'b1;
                    repeat (80) send_time(pick_time(), 1'b0);
                end
                if (p == 3 && n == 80) begin
                    drain_flows();
                end
                send_time(pick_time(), 1'b1);
            end
        end

        drain_flows();
        repeat (40) @(negedge aclk);
        $display("tb_top: %0d flow values checked over %0d gain settings",
                 flows.checked, gain_settings);
        $display("tb_top: covered time extremes and wrap, zero and full gain, stalls, long hold");
        if (flows.mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #5_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
